### rtl/stl_pkg.sv
// stl_pkg: shared types, token codes and constants for source_token_lexer.
// Used by stl_front, stl_back and source_token_lexer.
package stl_pkg;

  localparam int LINE_BITS_DEF = 16;
  localparam int COLUMN_BITS_DEF = 16;
  localparam int OUT_BITS = 16;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [5:0] {
    TK_ID, TK_NUM, TK_STR, TK_CHR,
    TK_ASSIGN, TK_EQ, TK_REBKT, TK_PLUS, TK_PLUS_AS, TK_MINUS, TK_MINUS_AS,
    TK_ARROW, TK_STAR, TK_STAR_AS, TK_SLASH, TK_SLASH_AS, TK_PCT, TK_PCT_AS,
    TK_PCT2, TK_PCT2_AS, TK_NOT, TK_NEQ, TK_GT, TK_GE, TK_LT, TK_LE,
    TK_AND, TK_OR, TK_DOT, TK_DOT2, TK_DOT2_EQ, TK_LBKT, TK_LEBKT, TK_RBKT,
    TK_LPAREN, TK_RPAREN, TK_LBRACE, TK_RBRACE, TK_COLON, TK_SEMI, TK_COMMA,
    TK_NONE
  } tok_t;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_NUM, M_NUM_DOT, M_STR, M_STR_ESC, M_CHR, M_CHR_ESC,
    M_HASH1, M_LINE, M_BLOCK, M_BLOCK_HASH, M_OP1, M_OP2
  } mode_t;

  typedef enum logic [2:0] {
    ERR_NONE, ERR_INVALID, ERR_STR, ERR_CHR, ERR_ESCAPE
  } err_t;

  localparam logic [7:0] CH_NL = 8'h0a;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_BSL = 8'h5c;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_DQ = 8'h22;
  localparam logic [7:0] CH_SQ = 8'h27;

  // one result word, before location is attached
  typedef struct packed {
    tok_t       ttype;
    logic [7:0] ch;
    logic       cv;
    logic       tend;
    err_t       err;
    logic       dotloc;   // located at held dot column instead of token start
  } res_t;

  // everything one step produces: up to three results with locations
  typedef struct packed {
    logic [1:0]          count;      // 1..3
    logic [1:0]          first_new;  // first result at the new token start; 3 if none
    res_t [2:0]          res;
    logic [OUT_BITS-1:0] line;
    logic [OUT_BITS-1:0] col;
    logic [OUT_BITS-1:0] dot_col;
    logic [OUT_BITS-1:0] new_line;
    logic [OUT_BITS-1:0] new_col;
  } step_t;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == " " || c == CH_TAB || c == CH_CR || c == CH_NL;
  endfunction

  function automatic logic is_look_op(logic [7:0] c);
    return c == "=" || c == "+" || c == "-" || c == "*" || c == "/" || c == "%" ||
           c == "!" || c == ">" || c == "<" || c == "&" || c == "|" || c == "." ||
           c == "[";
  endfunction

  function automatic tok_t single_type(logic [7:0] c);
    tok_t t;
    case (c)
      ":": t = TK_COLON;
      ";": t = TK_SEMI;
      "(": t = TK_LPAREN;
      ")": t = TK_RPAREN;
      "{": t = TK_LBRACE;
      "}": t = TK_RBRACE;
      "]": t = TK_RBKT;
      ",": t = TK_COMMA;
      default: t = TK_NONE;
    endcase
    return t;
  endfunction

  function automatic tok_t pair_type(logic [7:0] a, logic [7:0] b);
    tok_t t;
    t = TK_NONE;
    if (b == "=") begin
      case (a)
        "=": t = TK_EQ;
        "+": t = TK_PLUS_AS;
        "-": t = TK_MINUS_AS;
        "*": t = TK_STAR_AS;
        "/": t = TK_SLASH_AS;
        "%": t = TK_PCT_AS;
        "!": t = TK_NEQ;
        ">": t = TK_GE;
        "<": t = TK_LE;
        "[": t = TK_LEBKT;
        default: t = TK_NONE;
      endcase
    end else if (a == "=" && b == "]") t = TK_REBKT;
    else if (a == "-" && b == ">") t = TK_ARROW;
    else if (a == "&" && b == "&") t = TK_AND;
    else if (a == "|" && b == "|") t = TK_OR;
    return t;
  endfunction

  function automatic tok_t lone_type(logic [7:0] a);
    tok_t t;
    case (a)
      "=": t = TK_ASSIGN;
      "+": t = TK_PLUS;
      "-": t = TK_MINUS;
      "*": t = TK_STAR;
      "/": t = TK_SLASH;
      "%": t = TK_PCT;
      "!": t = TK_NOT;
      ">": t = TK_GT;
      "<": t = TK_LT;
      ".": t = TK_DOT;
      "[": t = TK_LBKT;
      default: t = TK_NONE;
    endcase
    return t;
  endfunction

endpackage

### rtl/stl_front.sv
// stl_front: scanner state machine; takes one byte per cycle when in_fire and
// pushes a step record (one to three results) into the queue. Uses stl_pkg.
module stl_front #(
  parameter int LINE_BITS = stl_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = stl_pkg::COLUMN_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_fire,
  input  logic           kind,
  input  logic [7:0]     char_in,
  output logic           push,
  output stl_pkg::step_t push_data
);

  stl_pkg::mode_t mode, mode_next;
  logic [7:0] held0, held0_next;
  logic has_dot, has_dot_next;
  logic halted, halted_next;
  logic [LINE_BITS-1:0] line;
  logic [COLUMN_BITS-1:0] col;
  logic [LINE_BITS-1:0] tline, tline_next;
  logic [COLUMN_BITS-1:0] tcol, tcol_next;
  logic [COLUMN_BITS-1:0] dcol, dcol_next;
  logic dot_used;

  stl_pkg::res_t [2:0] rs;
  logic [1:0] n;
  logic [1:0] fn;

  function automatic logic [stl_pkg::OUT_BITS-1:0] sat_l(logic [LINE_BITS-1:0] v);
    logic [stl_pkg::OUT_BITS-1:0] r;
    r = '1;
    if (LINE_BITS <= stl_pkg::OUT_BITS || v <= LINE_BITS'({stl_pkg::OUT_BITS{1'b1}}))
      r = stl_pkg::OUT_BITS'(v);
    return r;
  endfunction

  function automatic logic [stl_pkg::OUT_BITS-1:0] sat_c(logic [COLUMN_BITS-1:0] v);
    logic [stl_pkg::OUT_BITS-1:0] r;
    r = '1;
    if (COLUMN_BITS <= stl_pkg::OUT_BITS || v <= COLUMN_BITS'({stl_pkg::OUT_BITS{1'b1}}))
      r = stl_pkg::OUT_BITS'(v);
    return r;
  endfunction

  always_comb begin
    stl_pkg::mode_t m;
    stl_pkg::tok_t t;
    logic [7:0] c;
    logic again;
    logic s;
    logic [7:0] q;
    logic [7:0] d;
    logic dv;
    mode_next = mode;
    held0_next = held0;
    has_dot_next = has_dot;
    halted_next = halted;
    tline_next = tline;
    tcol_next = tcol;
    dcol_next = dcol;
    dot_used = 1'b0;
    rs = '0;
    n = 2'd0;
    fn = 2'd3;
    c = char_in;
    m = mode;
    again = 1'b0;
    t = stl_pkg::TK_NONE;
    s = 1'b0;
    q = 8'd0;
    d = 8'd0;
    dv = 1'b0;
    if (kind) begin
      if (!halted) begin
        case (mode)
          stl_pkg::M_IDENT: begin
            rs[0] = '{stl_pkg::TK_ID, 8'd0, 1'b0, 1'b1, stl_pkg::ERR_NONE, 1'b0}; n = 2'd1;
          end
          stl_pkg::M_NUM: begin
            rs[0] = '{stl_pkg::TK_NUM, 8'd0, 1'b0, 1'b1, stl_pkg::ERR_NONE, 1'b0}; n = 2'd1;
          end
          stl_pkg::M_NUM_DOT: begin
            rs[0] = '{stl_pkg::TK_NUM, 8'd0, 1'b0, 1'b1, stl_pkg::ERR_NONE, 1'b0};
            rs[1] = '{stl_pkg::TK_DOT, 8'd0, 1'b0, 1'b1, stl_pkg::ERR_NONE, 1'b1};
            n = 2'd2;
          end
          stl_pkg::M_OP1: begin
            t = stl_pkg::lone_type(held0);
            if (t == stl_pkg::TK_NONE)
              rs[0] = '{stl_pkg::TK_ID, 8'd0, 1'b0, 1'b1, stl_pkg::ERR_INVALID, 1'b0};
            else
              rs[0] = '{t, 8'd0, 1'b0, 1'b1, stl_pkg::ERR_NONE, 1'b0};
            n = 2'd1;
          end
          stl_pkg::M_OP2: begin
            rs[0] = '{(held0 == "%") ? stl_pkg::TK_PCT2 : stl_pkg::TK_DOT2, 8'd0, 1'b0,
                      1'b1, stl_pkg::ERR_NONE, 1'b0};
            n = 2'd1;
          end
          stl_pkg::M_STR, stl_pkg::M_STR_ESC: begin
            rs[0] = '{stl_pkg::TK_ID, 8'd0, 1'b0, 1'b1, stl_pkg::ERR_STR, 1'b0}; n = 2'd1;
          end
          stl_pkg::M_CHR, stl_pkg::M_CHR_ESC: begin
            rs[0] = '{stl_pkg::TK_ID, 8'd0, 1'b0, 1'b1, stl_pkg::ERR_CHR, 1'b0}; n = 2'd1;
          end
          default: n = 2'd0;
        endcase
      end
      mode_next = stl_pkg::M_IDLE;
      held0_next = 8'd0;
      has_dot_next = 1'b0;
      halted_next = 1'b0;
      tline_next = LINE_BITS'(1);
      tcol_next = '0;
      dcol_next = '0;
    end else if (!halted) begin
      // at most three passes: a number split at a held dot, then the dot
      // operator, then a new token
      for (int pass = 0; pass < 3; pass++) begin
        if (pass == 0 || again) begin
          again = 1'b0;
          case (m)
            stl_pkg::M_IDENT: begin
              if (stl_pkg::is_alpha(c) || stl_pkg::is_digit(c)) begin
                rs[n] = '{stl_pkg::TK_ID, c, 1'b1, 1'b0, stl_pkg::ERR_NONE, 1'b0}; n = n + 2'd1;
              end else begin
                rs[n] = '{stl_pkg::TK_ID, 8'd0, 1'b0, 1'b1, stl_pkg::ERR_NONE, 1'b0};
                n = n + 2'd1; m = stl_pkg::M_IDLE; again = 1'b1;
              end
            end
            stl_pkg::M_NUM: begin
              if (stl_pkg::is_digit(c)) begin
                rs[n] = '{stl_pkg::TK_NUM, c, 1'b1, 1'b0, stl_pkg::ERR_NONE, 1'b0}; n = n + 2'd1;
              end else if (c == "." && !has_dot_next) begin
                dcol_next = col; m = stl_pkg::M_NUM_DOT;
              end else begin
                rs[n] = '{stl_pkg::TK_NUM, 8'd0, 1'b0, 1'b1, stl_pkg::ERR_NONE, 1'b0};
                n = n + 2'd1; m = stl_pkg::M_IDLE; again = 1'b1;
              end
            end
            stl_pkg::M_NUM_DOT: begin
              if (stl_pkg::is_digit(c)) begin
                rs[n] = '{stl_pkg::TK_NUM, ".", 1'b1, 1'b0, stl_pkg::ERR_NONE, 1'b0};
                rs[n+1] = '{stl_pkg::TK_NUM, c, 1'b1, 1'b0, stl_pkg::ERR_NONE, 1'b0};
                n = n + 2'd2; has_dot_next = 1'b1; m = stl_pkg::M_NUM;
              end else begin
                rs[n] = '{stl_pkg::TK_NUM, 8'd0, 1'b0, 1'b1, stl_pkg::ERR_NONE, 1'b0};
                n = n + 2'd1;
                tcol_next = dcol; held0_next = "."; dot_used = 1'b1;
                m = stl_pkg::M_OP1; again = 1'b1;
              end
            end
            stl_pkg::M_OP1: begin
              if ((held0_next == "%" || held0_next == ".") && c == held0_next) begin
                m = stl_pkg::M_OP2;
              end else begin
                t = stl_pkg::pair_type(held0_next, c);
                if (t != stl_pkg::TK_NONE) begin
                  rs[n] = '{t, 8'd0, 1'b0, 1'b1, stl_pkg::ERR_NONE, dot_used};
                  n = n + 2'd1; m = stl_pkg::M_IDLE;
                end else begin
                  t = stl_pkg::lone_type(held0_next);
                  if (t == stl_pkg::TK_NONE) begin
                    rs[n] = '{stl_pkg::TK_ID, 8'd0, 1'b0, 1'b1, stl_pkg::ERR_INVALID, 1'b0};
                    n = n + 2'd1; halted_next = 1'b1; m = stl_pkg::M_IDLE;
                  end else begin
                    rs[n] = '{t, 8'd0, 1'b0, 1'b1, stl_pkg::ERR_NONE, dot_used};
                    n = n + 2'd1; m = stl_pkg::M_IDLE; again = 1'b1;
                  end
                end
              end
            end
            stl_pkg::M_OP2: begin
              m = stl_pkg::M_IDLE;
              if (c == "=") begin
                rs[n] = '{(held0 == "%") ? stl_pkg::TK_PCT2_AS : stl_pkg::TK_DOT2_EQ, 8'd0,
                          1'b0, 1'b1, stl_pkg::ERR_NONE, 1'b0};
                n = n + 2'd1;
              end else begin
                rs[n] = '{(held0 == "%") ? stl_pkg::TK_PCT2 : stl_pkg::TK_DOT2, 8'd0,
                          1'b0, 1'b1, stl_pkg::ERR_NONE, 1'b0};
                n = n + 2'd1; again = 1'b1;
              end
            end
            stl_pkg::M_HASH1: begin
              if (c == stl_pkg::CH_HASH) m = stl_pkg::M_BLOCK;
              else begin
                m = stl_pkg::M_LINE; again = 1'b1;
              end
            end
            stl_pkg::M_LINE: if (c == stl_pkg::CH_NL) m = stl_pkg::M_IDLE;
            stl_pkg::M_BLOCK: if (c == stl_pkg::CH_HASH) m = stl_pkg::M_BLOCK_HASH;
            stl_pkg::M_BLOCK_HASH:
              m = (c == stl_pkg::CH_HASH) ? stl_pkg::M_IDLE : stl_pkg::M_BLOCK;
            stl_pkg::M_STR, stl_pkg::M_CHR: begin
              s = (m == stl_pkg::M_STR);
              q = s ? stl_pkg::CH_DQ : stl_pkg::CH_SQ;
              if (c == q) begin
                rs[n] = '{s ? stl_pkg::TK_STR : stl_pkg::TK_CHR, 8'd0, 1'b0, 1'b1,
                          stl_pkg::ERR_NONE, 1'b0};
                n = n + 2'd1; m = stl_pkg::M_IDLE;
              end else if (c == stl_pkg::CH_NL) begin
                rs[n] = '{stl_pkg::TK_ID, 8'd0, 1'b0, 1'b1,
                          s ? stl_pkg::ERR_STR : stl_pkg::ERR_CHR, 1'b0};
                n = n + 2'd1; halted_next = 1'b1; m = stl_pkg::M_IDLE;
              end else if (c == stl_pkg::CH_BSL) begin
                m = s ? stl_pkg::M_STR_ESC : stl_pkg::M_CHR_ESC;
              end else begin
                rs[n] = '{s ? stl_pkg::TK_STR : stl_pkg::TK_CHR, c, 1'b1, 1'b0,
                          stl_pkg::ERR_NONE, 1'b0};
                n = n + 2'd1;
              end
            end
            stl_pkg::M_STR_ESC, stl_pkg::M_CHR_ESC: begin
              s = (m == stl_pkg::M_STR_ESC);
              q = s ? stl_pkg::CH_DQ : stl_pkg::CH_SQ;
              dv = 1'b1;
              case (c)
                "n": d = stl_pkg::CH_NL;
                "t": d = stl_pkg::CH_TAB;
                "r": d = stl_pkg::CH_CR;
                stl_pkg::CH_BSL: d = stl_pkg::CH_BSL;
                default: begin
                  d = q; dv = (c == q);
                end
              endcase
              if (!dv) begin
                rs[n] = '{stl_pkg::TK_ID, 8'd0, 1'b0, 1'b1, stl_pkg::ERR_ESCAPE, 1'b0};
                n = n + 2'd1; halted_next = 1'b1; m = stl_pkg::M_IDLE;
              end else begin
                rs[n] = '{s ? stl_pkg::TK_STR : stl_pkg::TK_CHR, d, 1'b1, 1'b0,
                          stl_pkg::ERR_NONE, 1'b0};
                n = n + 2'd1; m = s ? stl_pkg::M_STR : stl_pkg::M_CHR;
              end
            end
            default: begin
              m = stl_pkg::M_IDLE;
              if (!stl_pkg::is_space(c)) begin
                tline_next = line; tcol_next = col; dot_used = 1'b0; fn = n;
                if (stl_pkg::is_alpha(c)) begin
                  m = stl_pkg::M_IDENT;
                  rs[n] = '{stl_pkg::TK_ID, c, 1'b1, 1'b0, stl_pkg::ERR_NONE, 1'b0};
                  n = n + 2'd1;
                end else if (stl_pkg::is_digit(c)) begin
                  m = stl_pkg::M_NUM; has_dot_next = 1'b0;
                  rs[n] = '{stl_pkg::TK_NUM, c, 1'b1, 1'b0, stl_pkg::ERR_NONE, 1'b0};
                  n = n + 2'd1;
                end else if (c == stl_pkg::CH_DQ) m = stl_pkg::M_STR;
                else if (c == stl_pkg::CH_SQ) m = stl_pkg::M_CHR;
                else if (c == stl_pkg::CH_HASH) m = stl_pkg::M_HASH1;
                else if (stl_pkg::is_look_op(c)) begin
                  held0_next = c; m = stl_pkg::M_OP1;
                end else begin
                  t = stl_pkg::single_type(c);
                  if (t != stl_pkg::TK_NONE)
                    rs[n] = '{t, 8'd0, 1'b0, 1'b1, stl_pkg::ERR_NONE, 1'b0};
                  else begin
                    rs[n] = '{stl_pkg::TK_ID, 8'd0, 1'b0, 1'b1, stl_pkg::ERR_INVALID, 1'b0};
                    halted_next = 1'b1;
                  end
                  n = n + 2'd1;
                end
              end
            end
          endcase
        end
      end
      mode_next = m;
    end
  end

  // results before a restart keep the old start; those after use the new one
  always_comb begin
    push = in_fire && (n != 2'd0);
    push_data.count = n;
    push_data.first_new = fn;
    push_data.res = rs;
    push_data.line = sat_l(tline);
    push_data.col = sat_c(tcol);
    push_data.dot_col = sat_c(dcol);
    push_data.new_line = sat_l(line);
    push_data.new_col = sat_c(col);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= stl_pkg::M_IDLE;
      held0 <= '0;
      has_dot <= 1'b0;
      halted <= 1'b0;
      line <= LINE_BITS'(1);
      col <= '0;
      tline <= LINE_BITS'(1);
      tcol <= '0;
      dcol <= '0;
    end else if (in_fire) begin
      mode <= mode_next;
      held0 <= held0_next;
      has_dot <= has_dot_next;
      halted <= halted_next;
      tline <= tline_next;
      tcol <= tcol_next;
      dcol <= dcol_next;
      if (kind) begin
        line <= LINE_BITS'(1);
        col <= '0;
      end else if (!halted) begin
        if (char_in == stl_pkg::CH_NL) begin
          if (line != '1) line <= line + LINE_BITS'(1);
          col <= '0;
        end else if (col != '1) begin
          col <= col + COLUMN_BITS'(1);
        end
      end
    end
  end

endmodule

### rtl/stl_back.sv
// stl_back: step queue and output sequencer; pops a step record and sends
// its results one per cycle, unless stalled, via an output register. Uses stl_pkg.
module stl_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  stl_pkg::step_t push_data,
  output logic           space,
  output logic           empty,
  output logic [5:0]     token_type,
  output logic [7:0]     lexeme_char,
  output logic           char_valid,
  output logic           token_end,
  output logic [15:0]    start_line,
  output logic [15:0]    start_column,
  output logic [2:0]     error_code,
  output logic           last,
  output logic           out_valid,
  input  logic           out_ready
);

  localparam int AW = $clog2(stl_pkg::QUEUE_DEPTH);

  stl_pkg::step_t q [stl_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr, rd;
  logic [AW:0] fill;
  logic [1:0] idx;
  logic pop_step, load;
  stl_pkg::step_t head;
  stl_pkg::res_t r;

  assign head = q[rd];
  assign r = head.res[idx];
  assign load = (fill != '0) && (!out_valid || out_ready);
  assign pop_step = load && (idx == head.count - 2'd1);
  // every slot is usable; space ignores a pop in flight, so the front never checks one
  assign space = fill < (AW+1)'(stl_pkg::QUEUE_DEPTH);
  assign empty = (fill == '0) && !out_valid;

  always_ff @(posedge clk) begin
    if (push) q[wr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr <= '0;
      rd <= '0;
      fill <= '0;
      idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (push) wr <= wr + AW'(1);
      if (pop_step) begin
        rd <= rd + AW'(1);
        idx <= '0;
      end else if (load) begin
        idx <= idx + 2'd1;
      end
      fill <= fill + (AW+1)'(push) - (AW+1)'(pop_step);
      if (load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      token_type <= r.ttype;
      lexeme_char <= r.ch;
      char_valid <= r.cv;
      token_end <= r.tend;
      start_line <= (idx >= head.first_new) ? head.new_line : head.line;
      start_column <= (idx >= head.first_new) ? head.new_col :
                      (r.dotloc ? head.dot_col : head.col);
      error_code <= r.err;
      last <= pop_step;
    end
  end

endmodule

### rtl/source_token_lexer.sv
// source_token_lexer: top level, front scanner plus back result sequencer.
// Depends on stl_pkg, stl_front and stl_back.
//
// Input channel (valid/ready): kind and char_in, one byte or an end-of-input
// mark per transfer. Output channel (valid/ready): one token result per
// transfer; last marks the final result caused by one input.
// The scanner takes one byte per cycle whenever the step queue has room;
// each byte gives zero to three results, sent one per cycle unless stalled.
// An input's first result goes through the step queue, then the output
// register. Sustained rate is one byte per cycle while bytes give at
// most one result each; bursts of multi-result steps are absorbed by the
// 4-entry step queue, and the output port then sets the rate.
// When the receiver stalls, results wait in the output register and queue;
// the input keeps being taken until the queue is full.
// Reset (synchronous) clears scanner state to line 1, column 0, idle, and
// empties the queue.
// A token's start is kept in the record of the step that emits it; a
// number split off a held dot reports the dot's own column for the operator.
module source_token_lexer #(
  parameter int LINE_BITS = stl_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = stl_pkg::COLUMN_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [7:0]  char_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  token_type,
  output logic [7:0]  lexeme_char,
  output logic        char_valid,
  output logic        token_end,
  output logic [15:0] start_line,
  output logic [15:0] start_column,
  output logic [2:0]  error_code,
  output logic        last
);

  logic in_fire, push, space, empty;
  stl_pkg::step_t step;

  assign in_ready = space;
  assign in_fire = in_valid && in_ready;

  stl_front #(.LINE_BITS(LINE_BITS), .COLUMN_BITS(COLUMN_BITS)) u_front (
    .clk, .rst, .in_fire, .kind, .char_in, .push, .push_data(step)
  );

  stl_back u_back (
    .clk, .rst, .push, .push_data(step), .space, .empty,
    .token_type, .lexeme_char, .char_valid, .token_end, .start_line,
    .start_column, .error_code, .last, .out_valid, .out_ready
  );

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push |-> space) else $error("push into full step queue");

  a_err_ends_token: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code != stl_pkg::ERR_NONE |-> token_end && !char_valid)
    else $error("error result without token end");

  a_char_not_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && char_valid |-> !token_end) else $error("char result ends token");

  a_empty_idle: assert property (@(posedge clk) disable iff (rst)
    empty |-> !out_valid) else $error("empty back end shows a result");

endmodule

### tb/tb_source_token_lexer.sv
// Testbench for source_token_lexer: drives byte streams, predicts each token
// result in a local scanner model and compares results in arrival order.
// Depends on stl_pkg and the source_token_lexer RTL.
module tb_source_token_lexer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_EOI = 1'b1;

  typedef struct packed {
    logic [5:0]  ttype;
    logic [7:0]  ch;
    logic        cv;
    logic        tend;
    logic [15:0] line;
    logic [15:0] col;
    logic [2:0]  err;
    logic        lst;
  } tok_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        kind = KIND_CHAR;
  logic [7:0]  char_in = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [5:0]  token_type;
  logic [7:0]  lexeme_char;
  logic        char_valid;
  logic        token_end;
  logic [15:0] start_line;
  logic [15:0] start_column;
  logic [2:0]  error_code;
  logic        last;

  source_token_lexer uut (.*);

  always #5 clk = ~clk;

  // predictor state
  stl_pkg::mode_t lx_mode;
  logic [15:0] lx_held;
  logic        lx_has_dot;
  logic        lx_halted;
  logic [15:0] lx_line, lx_col, lx_tok_line, lx_tok_col, lx_dot_col;
  tok_res_t    expected_tokens[$];
  tok_res_t    step_res[$];

  int errors = 0;
  int results_seen = 0;
  int items_sent = 0;
  int burst_left = 0;

  task automatic lexer_reset_state();
    lx_mode = stl_pkg::M_IDLE; lx_held = '0; lx_has_dot = 0; lx_halted = 0;
    lx_line = 1; lx_col = 0; lx_tok_line = 1; lx_tok_col = 0; lx_dot_col = 0;
  endtask

  function automatic logic alpha_c(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
  endfunction
  function automatic logic digit_c(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction
  function automatic logic space_c(logic [7:0] c);
    return c == 8'h20 || c == stl_pkg::CH_TAB || c == stl_pkg::CH_CR || c == stl_pkg::CH_NL;
  endfunction
  function automatic logic look_c(logic [7:0] c);
    return c inside {"=", "+", "-", "*", "/", "%", "!", ">", "<", "&", "|", ".", "["};
  endfunction
  function automatic stl_pkg::tok_t single_of(logic [7:0] c);
    case (c)
      ":": return stl_pkg::TK_COLON;
      ";": return stl_pkg::TK_SEMI;
      "(": return stl_pkg::TK_LPAREN;
      ")": return stl_pkg::TK_RPAREN;
      "{": return stl_pkg::TK_LBRACE;
      "}": return stl_pkg::TK_RBRACE;
      "]": return stl_pkg::TK_RBKT;
      ",": return stl_pkg::TK_COMMA;
      default: return stl_pkg::TK_NONE;
    endcase
  endfunction
  function automatic stl_pkg::tok_t pair_of(logic [7:0] a, logic [7:0] b);
    if (b == "=") begin
      case (a)
        "=": return stl_pkg::TK_EQ;
        "+": return stl_pkg::TK_PLUS_AS;
        "-": return stl_pkg::TK_MINUS_AS;
        "*": return stl_pkg::TK_STAR_AS;
        "/": return stl_pkg::TK_SLASH_AS;
        "%": return stl_pkg::TK_PCT_AS;
        "!": return stl_pkg::TK_NEQ;
        ">": return stl_pkg::TK_GE;
        "<": return stl_pkg::TK_LE;
        "[": return stl_pkg::TK_LEBKT;
        default: return stl_pkg::TK_NONE;
      endcase
    end
    if (a == "=" && b == "]") return stl_pkg::TK_REBKT;
    if (a == "-" && b == ">") return stl_pkg::TK_ARROW;
    if (a == "&" && b == "&") return stl_pkg::TK_AND;
    if (a == "|" && b == "|") return stl_pkg::TK_OR;
    return stl_pkg::TK_NONE;
  endfunction
  function automatic stl_pkg::tok_t lone_of(logic [7:0] a);
    case (a)
      "=": return stl_pkg::TK_ASSIGN;
      "+": return stl_pkg::TK_PLUS;
      "-": return stl_pkg::TK_MINUS;
      "*": return stl_pkg::TK_STAR;
      "/": return stl_pkg::TK_SLASH;
      "%": return stl_pkg::TK_PCT;
      "!": return stl_pkg::TK_NOT;
      ">": return stl_pkg::TK_GT;
      "<": return stl_pkg::TK_LT;
      ".": return stl_pkg::TK_DOT;
      "[": return stl_pkg::TK_LBKT;
      default: return stl_pkg::TK_NONE;
    endcase
  endfunction

  task automatic put(stl_pkg::tok_t t, logic [7:0] c, logic cv, logic tend,
                     stl_pkg::err_t e);
    tok_res_t r;
    if (step_res.size() >= 3) return;
    r.ttype = t; r.ch = c; r.cv = cv; r.tend = tend;
    r.line = lx_tok_line; r.col = lx_tok_col; r.err = e; r.lst = 0;
    step_res.push_back(r);
  endtask

  task automatic raise_error(stl_pkg::err_t e);
    put(stl_pkg::TK_ID, 0, 0, 1, e);
    lx_halted = 1;
    lx_mode = stl_pkg::M_IDLE;
  endtask

  task automatic split_number_dot();
    put(stl_pkg::TK_NUM, 0, 0, 1, stl_pkg::ERR_NONE);
    lx_tok_col = lx_dot_col;
    lx_held = 16'(".");
    lx_mode = stl_pkg::M_OP1;
  endtask

  task automatic begin_token(logic [7:0] c);
    stl_pkg::tok_t t;
    if (space_c(c)) return;
    lx_tok_line = lx_line;
    lx_tok_col = lx_col;
    if (alpha_c(c)) begin
      lx_mode = stl_pkg::M_IDENT; put(stl_pkg::TK_ID, c, 1, 0, stl_pkg::ERR_NONE);
    end else if (digit_c(c)) begin
      lx_mode = stl_pkg::M_NUM; lx_has_dot = 0;
      put(stl_pkg::TK_NUM, c, 1, 0, stl_pkg::ERR_NONE);
    end else if (c == stl_pkg::CH_DQ) lx_mode = stl_pkg::M_STR;
    else if (c == stl_pkg::CH_SQ) lx_mode = stl_pkg::M_CHR;
    else if (c == stl_pkg::CH_HASH) lx_mode = stl_pkg::M_HASH1;
    else if (look_c(c)) begin
      lx_held = {8'h00, c}; lx_mode = stl_pkg::M_OP1;
    end else begin
      t = single_of(c);
      if (t != stl_pkg::TK_NONE) put(t, 0, 0, 1, stl_pkg::ERR_NONE);
      else raise_error(stl_pkg::ERR_INVALID);
    end
  endtask

  task automatic scan_byte(logic [7:0] c);
    logic [7:0]    first;
    logic          again;
    logic          s;
    logic [7:0]    q;
    stl_pkg::tok_t t;
    again = 1;
    while (again) begin
      again = 0;
      first = lx_held[7:0];
      case (lx_mode)
        stl_pkg::M_IDENT: begin
          if (alpha_c(c) || digit_c(c)) put(stl_pkg::TK_ID, c, 1, 0, stl_pkg::ERR_NONE);
          else begin
            put(stl_pkg::TK_ID, 0, 0, 1, stl_pkg::ERR_NONE);
            lx_mode = stl_pkg::M_IDLE; again = 1;
          end
        end
        stl_pkg::M_NUM: begin
          if (digit_c(c)) put(stl_pkg::TK_NUM, c, 1, 0, stl_pkg::ERR_NONE);
          else if (c == "." && !lx_has_dot) begin
            lx_dot_col = lx_col; lx_mode = stl_pkg::M_NUM_DOT;
          end else begin
            put(stl_pkg::TK_NUM, 0, 0, 1, stl_pkg::ERR_NONE);
            lx_mode = stl_pkg::M_IDLE; again = 1;
          end
        end
        stl_pkg::M_NUM_DOT: begin
          if (digit_c(c)) begin
            put(stl_pkg::TK_NUM, ".", 1, 0, stl_pkg::ERR_NONE);
            put(stl_pkg::TK_NUM, c, 1, 0, stl_pkg::ERR_NONE);
            lx_has_dot = 1; lx_mode = stl_pkg::M_NUM;
          end else begin
            split_number_dot(); again = 1;
          end
        end
        stl_pkg::M_OP1: begin
          t = pair_of(first, c);
          if ((first == "%" || first == ".") && c == first) begin
            lx_held = {c, first}; lx_mode = stl_pkg::M_OP2;
          end else if (t != stl_pkg::TK_NONE) begin
            put(t, 0, 0, 1, stl_pkg::ERR_NONE); lx_mode = stl_pkg::M_IDLE;
          end else if (lone_of(first) == stl_pkg::TK_NONE) raise_error(stl_pkg::ERR_INVALID);
          else begin
            put(lone_of(first), 0, 0, 1, stl_pkg::ERR_NONE);
            lx_mode = stl_pkg::M_IDLE; again = 1;
          end
        end
        stl_pkg::M_OP2: begin
          lx_mode = stl_pkg::M_IDLE;
          if (c == "=")
            put(first == "%" ? stl_pkg::TK_PCT2_AS : stl_pkg::TK_DOT2_EQ, 0, 0, 1,
                stl_pkg::ERR_NONE);
          else begin
            put(first == "%" ? stl_pkg::TK_PCT2 : stl_pkg::TK_DOT2, 0, 0, 1,
                stl_pkg::ERR_NONE);
            again = 1;
          end
        end
        stl_pkg::M_HASH1: begin
          if (c == stl_pkg::CH_HASH) lx_mode = stl_pkg::M_BLOCK;
          else begin
            lx_mode = stl_pkg::M_LINE; again = 1;
          end
        end
        stl_pkg::M_LINE: if (c == stl_pkg::CH_NL) lx_mode = stl_pkg::M_IDLE;
        stl_pkg::M_BLOCK: if (c == stl_pkg::CH_HASH) lx_mode = stl_pkg::M_BLOCK_HASH;
        stl_pkg::M_BLOCK_HASH:
          lx_mode = (c == stl_pkg::CH_HASH) ? stl_pkg::M_IDLE : stl_pkg::M_BLOCK;
        stl_pkg::M_STR, stl_pkg::M_CHR: begin
          s = (lx_mode == stl_pkg::M_STR);
          q = s ? stl_pkg::CH_DQ : stl_pkg::CH_SQ;
          if (c == q) begin
            put(s ? stl_pkg::TK_STR : stl_pkg::TK_CHR, 0, 0, 1, stl_pkg::ERR_NONE);
            lx_mode = stl_pkg::M_IDLE;
          end else if (c == stl_pkg::CH_NL)
            raise_error(s ? stl_pkg::ERR_STR : stl_pkg::ERR_CHR);
          else if (c == stl_pkg::CH_BSL) lx_mode = s ? stl_pkg::M_STR_ESC : stl_pkg::M_CHR_ESC;
          else put(s ? stl_pkg::TK_STR : stl_pkg::TK_CHR, c, 1, 0, stl_pkg::ERR_NONE);
        end
        stl_pkg::M_STR_ESC, stl_pkg::M_CHR_ESC: begin
          s = (lx_mode == stl_pkg::M_STR_ESC);
          q = s ? stl_pkg::CH_DQ : stl_pkg::CH_SQ;
          if (c == "n") q = stl_pkg::CH_NL;
          else if (c == "t") q = stl_pkg::CH_TAB;
          else if (c == "r") q = stl_pkg::CH_CR;
          else if (c == stl_pkg::CH_BSL) q = stl_pkg::CH_BSL;
          else if (c != q) q = 8'h00;
          if (q == 8'h00) raise_error(stl_pkg::ERR_ESCAPE);
          else begin
            put(s ? stl_pkg::TK_STR : stl_pkg::TK_CHR, q, 1, 0, stl_pkg::ERR_NONE);
            lx_mode = s ? stl_pkg::M_STR : stl_pkg::M_CHR;
          end
        end
        default: begin
          lx_mode = stl_pkg::M_IDLE; begin_token(c);
        end
      endcase
    end
  endtask

  task automatic flush_input();
    case (lx_mode)
      stl_pkg::M_IDENT: put(stl_pkg::TK_ID, 0, 0, 1, stl_pkg::ERR_NONE);
      stl_pkg::M_NUM: put(stl_pkg::TK_NUM, 0, 0, 1, stl_pkg::ERR_NONE);
      stl_pkg::M_NUM_DOT: begin
        split_number_dot(); put(stl_pkg::TK_DOT, 0, 0, 1, stl_pkg::ERR_NONE);
      end
      stl_pkg::M_OP1: begin
        if (lone_of(lx_held[7:0]) == stl_pkg::TK_NONE) raise_error(stl_pkg::ERR_INVALID);
        else put(lone_of(lx_held[7:0]), 0, 0, 1, stl_pkg::ERR_NONE);
      end
      stl_pkg::M_OP2:
        put(lx_held[7:0] == "%" ? stl_pkg::TK_PCT2 : stl_pkg::TK_DOT2, 0, 0, 1,
            stl_pkg::ERR_NONE);
      stl_pkg::M_STR, stl_pkg::M_STR_ESC: raise_error(stl_pkg::ERR_STR);
      stl_pkg::M_CHR, stl_pkg::M_CHR_ESC: raise_error(stl_pkg::ERR_CHR);
      default: ;
    endcase
  endtask

  // advance the model by one input and queue the results it causes
  task automatic predict_tokens(logic k, logic [7:0] c);
    step_res.delete();
    if (k == KIND_EOI) begin
      if (!lx_halted) flush_input();
      lexer_reset_state();
    end else if (!lx_halted) begin
      scan_byte(c);
      if (c == stl_pkg::CH_NL) begin
        if (lx_line != 16'hffff) lx_line++;
        lx_col = 0;
      end else if (lx_col != 16'hffff) lx_col++;
    end
    if (step_res.size() > 0) step_res[step_res.size()-1].lst = 1;
    foreach (step_res[i]) expected_tokens.push_back(step_res[i]);
  endtask

  // hold valid across back-to-back transfers; gaps come between bursts
  task automatic send_byte(logic k, logic [7:0] c);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    kind <= k;
    char_in <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_tokens(k, c);
    items_sent++;
    burst_left--;
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_byte(KIND_CHAR, s[i]);
  endtask

  task automatic end_input();
    send_byte(KIND_EOI, $urandom_range(0, 255));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_tokens.size() != 0) @(posedge clk);
  endtask

  // receiver stall pattern: alternate ready stretches and stall stretches
  initial begin
    int n;
    @(negedge rst);
    forever begin
      n = $urandom_range(1, 20);
      repeat (n) @(posedge clk) out_ready <= 1'b1;
      n = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      repeat (n) @(posedge clk) out_ready <= ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    tok_res_t w;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_tokens.size() == 0) begin
        $error("unexpected result type=%0d char=%0h", token_type, lexeme_char);
        errors++;
      end else begin
        w = expected_tokens.pop_front();
        if (token_type !== w.ttype) begin
          $error("token_type exp %0d got %0d", w.ttype, token_type); errors++;
        end
        if (lexeme_char !== w.ch) begin
          $error("lexeme_char exp %0h got %0h", w.ch, lexeme_char); errors++;
        end
        if (char_valid !== w.cv) begin
          $error("char_valid exp %0d got %0d", w.cv, char_valid); errors++;
        end
        if (token_end !== w.tend) begin
          $error("token_end exp %0d got %0d", w.tend, token_end); errors++;
        end
        if (start_line !== w.line) begin
          $error("start_line exp %0d got %0d", w.line, start_line); errors++;
        end
        if (start_column !== w.col) begin
          $error("start_column exp %0d got %0d", w.col, start_column); errors++;
        end
        if (error_code !== w.err) begin
          $error("error_code exp %0d got %0d", w.err, error_code); errors++;
        end
        if (last !== w.lst) begin
          $error("last exp %0d got %0d", w.lst, last); errors++;
        end
      end
    end
  end

  task automatic test_operators();
    send_text("= == =] + += - -= -> * *= / /= % %= %% %%= ! != > >= < <= && || . .. ..= [ [=");
    send_text(" ] ( ) { } : ; ,%%");
    end_input();
  endtask

  task automatic test_literals();
    send_text("ab_9 1.5.x 7..y 3.");
    end_input();
    send_text("\"a\\n\\t\\r\\\\\\\"\" 'x\\'' #c\n##a#b##z");
    end_input();
  endtask

  task automatic test_errors();
    send_text("\"ab\nq");
    end_input();
    send_text("'\\q'");
    end_input();
    send_text("a&b");
    end_input();
    send_byte(KIND_CHAR, 8'hff);
    end_input();
    send_text("'ab");
    end_input();
    send_byte(KIND_CHAR, "|");
    end_input();
  endtask

  function automatic string pick_fragment();
    string frags[] = '{"foo", "x1_", "42", "3.14", "9.8.7", "\"s\\t\"", "'c'", "'\\n'",
                       "#cmt\n", "##b#l##", " ", "\n", "\t", "\r", "..=", "%%=", "->",
                       "=]", "[=", "&&", "||", "+=", "<=", "!=", "(", "}", ";", ",", "1.",
                       "\"u", "\\", "'\\z'", "&", "@"};
    return frags[$urandom_range(0, frags.size() - 1)];
  endfunction

  task automatic test_random_stream();
    int budget;
    budget = 0;
    while (budget < 10) begin
      if ($urandom_range(0, 9) == 0) begin
        send_byte(KIND_CHAR, $urandom_range(0, 255));
        budget++;
      end else if ($urandom_range(0, 24) == 0) begin
        end_input();
        budget++;
      end else begin
        string f;
        f = pick_fragment();
        send_text(f);
        budget += f.len();
      end
    end
    end_input();
  endtask

  initial begin
    lexer_reset_state();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_operators();
    test_literals();
    test_errors();
    drain_results();
    test_random_stream();
    drain_results();
    repeat (10) @(posedge clk);
    $display("Sent %0d input transfers; checked %0d token results.", items_sent, results_seen);
    $display("Covered operators, literals, escapes, comments, errors and random streams.");
    if (errors == 0 && expected_tokens.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule

### files.f
rtl/stl_pkg.sv
rtl/stl_front.sv
rtl/stl_back.sv
rtl/source_token_lexer.sv
tb/tb_source_token_lexer.sv
